// File: src/lfss_pkg.sv
// Shared types, codes and the sensor steering table for the line-follow
// steering sequencer. No dependencies.
package lfss_pkg;

  localparam int SERVO_W  = 7;
  localparam int SPEED_W  = 10;
  localparam int TICK_W   = 16;
  localparam int BLOCK_W  = 8;
  localparam int PHASE_W  = 2;
  localparam int SENS_W   = 8;
  localparam int HITS_W   = 4;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  // Input item kinds
  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_SPEED   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_SPEED   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_BLOCKS  = 2'd3;

  // Turn tracker phases
  localparam logic [PHASE_W-1:0] PHASE_NONE    = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_RIGHT   = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_DONE    = 2'd2;
  localparam logic [PHASE_W-1:0] PHASE_SETTLED = 2'd3;

  localparam logic [SERVO_W-1:0] SERVO_CENTRE   = 7'd70;
  localparam logic [SERVO_W-1:0] SERVO_HI_LIMIT = 7'd80;
  localparam logic [SERVO_W-1:0] SLEW_FINE      = 7'd1;
  localparam logic [SERVO_W-1:0] SLEW_COARSE    = 7'd5;

  localparam logic [SPEED_W-1:0] SPEED_RESET      = 10'd180;
  localparam logic [SPEED_W-1:0] SLOW_SPEED_RESET = 10'd90;
  localparam logic [SPEED_W-1:0] FAST_SPEED_RESET = 10'd120;
  localparam logic [BLOCK_W-1:0] BLOCKS_RESET     = 8'd50;
  localparam logic [BLOCK_W-1:0] SLOW_BLOCKS_RESET = 8'd30;

  typedef struct packed {
    logic [SERVO_W-1:0] servo_pos;
    logic [SERVO_W-1:0] steer;
    logic [TICK_W-1:0]  tick_count;
    logic [BLOCK_W-1:0] blocks_left;
    logic [PHASE_W-1:0] phase;
    logic               halted;
    logic [SPEED_W-1:0] speed;
  } lfss_state_t;

  typedef struct packed {
    logic [TICK_W-1:0]  interval_thr;
    logic [SPEED_W-1:0] slow_speed;
    logic [SPEED_W-1:0] fast_speed;
    logic [BLOCK_W-1:0] slow_blocks;
  } lfss_cfg_t;

  typedef struct packed {
    logic               servo_write;
    logic [SERVO_W-1:0] servo_value;
    logic [SPEED_W-1:0] speed_target;
    logic               pid_preset;
    logic               brake;
    logic               stopped;
    logic [PHASE_W-1:0] turn_state;
    logic [HITS_W-1:0]  hit_count;
  } lfss_result_t;

  // Steer target for the sensor at position idx (sensor idx+1)
  function automatic logic [SERVO_W-1:0] steer_lookup(input logic [2:0] idx);
    logic [SERVO_W-1:0] v;
    case (idx)
      3'd0:    v = 7'd95;
      3'd1:    v = 7'd90;
      3'd2:    v = 7'd85;
      3'd3:    v = 7'd80;
      3'd4:    v = 7'd70;
      3'd5:    v = 7'd60;
      3'd6:    v = 7'd57;
      3'd7:    v = 7'd55;
      default: v = SERVO_CENTRE;
    endcase
    return v;
  endfunction

endpackage

// File: src/lfss_step.sv
// Next-state and result logic for one item of the steering sequencer.
// Purely combinational; depends on lfss_pkg.
module lfss_step (
  input  logic                 kind,
  input  logic [7:0]           sensors,
  input  lfss_pkg::lfss_state_t st,
  input  lfss_pkg::lfss_cfg_t   cfg,
  output lfss_pkg::lfss_state_t st_nxt,
  output lfss_pkg::lfss_result_t res
);
  import lfss_pkg::*;

  logic [HITS_W-1:0]  hits;
  logic [2:0]         top_idx;
  logic [SERVO_W-1:0] tgt;
  logic [SERVO_W-1:0] gap;
  logic [SERVO_W-1:0] step;
  logic [BLOCK_W-1:0] blocks_dec;
  logic [PHASE_W-1:0] phase_a;
  logic [PHASE_W-1:0] phase_b;
  logic [SPEED_W-1:0] spd;
  logic [TICK_W-1:0]  interval;

  // Count set sensors and find the highest-numbered one
  always_comb begin
    hits    = '0;
    top_idx = '0;
    for (int i = 0; i < SENS_W; i++) begin
      if (sensors[i]) begin
        hits    = hits + HITS_W'(1);
        top_idx = 3'(i);
      end
    end
  end

  assign tgt        = steer_lookup(top_idx);
  assign blocks_dec = st.blocks_left - BLOCK_W'(1);
  assign interval   = st.tick_count;
  assign gap        = (st.servo_pos < st.steer) ? (st.steer - st.servo_pos)
                                                : (st.servo_pos - st.steer);
  assign step       = (gap < SLEW_COARSE) ? SLEW_FINE : SLEW_COARSE;

  always_comb begin
    st_nxt = st;
    res    = '0;
    phase_a = st.phase;
    phase_b = st.phase;
    spd     = st.speed;

    if (!st.halted) begin
      if (kind == KIND_TICK) begin
        if (st.servo_pos < st.steer) begin
          st_nxt.servo_pos = st.servo_pos + step;
          res.servo_write  = 1'b1;
          res.servo_value  = st.servo_pos + step;
        end else if (st.servo_pos > st.steer) begin
          st_nxt.servo_pos = st.servo_pos - step;
          res.servo_write  = 1'b1;
          res.servo_value  = st.servo_pos - step;
        end
        st_nxt.tick_count = st.tick_count + TICK_W'(1);
      end else if (sensors != '0) begin
        st_nxt.blocks_left = blocks_dec;
        st_nxt.tick_count  = '0;
        res.hit_count      = hits;
        if (hits == HITS_W'(1)) begin
          st_nxt.steer = tgt;
          if (blocks_dec < cfg.slow_blocks) spd = cfg.slow_speed;
          // Tracker: a hard-right target arms, a later hit that is not hard right completes the turn
          if (tgt > SERVO_HI_LIMIT) begin
            phase_a = PHASE_RIGHT;
          end else if (st.phase == PHASE_RIGHT) begin
            phase_a = PHASE_DONE;
          end
          phase_b = phase_a;
          if (phase_a == PHASE_DONE) begin
            spd             = cfg.fast_speed;
            res.pid_preset  = 1'b1;
            res.servo_write = 1'b1;
            res.servo_value = SERVO_CENTRE;
            phase_b         = PHASE_SETTLED;
          end
          if (phase_b == PHASE_SETTLED) begin
            if (interval != cfg.interval_thr) spd = cfg.slow_speed;
          end else begin
            if (interval < cfg.interval_thr) begin
              spd = cfg.slow_speed;
            end else if (interval > cfg.interval_thr) begin
              spd = cfg.fast_speed;
            end
          end
          st_nxt.phase = phase_b;
          st_nxt.speed = spd;
        end else begin
          // Crossing line: centre the servo, brake and stop for good
          st_nxt.steer    = SERVO_CENTRE;
          st_nxt.halted   = 1'b1;
          res.servo_write = 1'b1;
          res.servo_value = SERVO_CENTRE;
          res.brake       = 1'b1;
        end
      end
    end

    res.speed_target = st_nxt.speed;
    res.stopped      = st_nxt.halted;
    res.turn_state   = st_nxt.phase;
  end

endmodule

// File: src/line_follow_steering_sequencer_core.sv
// Top level of the line-follow steering sequencer: input register, state,
// configuration registers and result register. Depends on lfss_pkg, lfss_step.
//
// Takes one item per clock and gives one result per item. An accepted item
// sits in the input register; the step logic evaluates it combinationally
// against the tracker state and the result register captures the outcome
// once it is free or its result is taken, which raises out_valid; the
// sustained rate is one item per cycle, limited only by out_ready. While a
// result waits, the input register still takes one item if it is empty and
// holds it until the result moves on. Once a multi-sensor sample has braked
// the block, every later item returns stopped with no servo write. The
// running total time and the stored interval of the tracker are not kept as
// registers: the interval compared on a sample is the tick count at that
// sample, and nothing else reads them.
module line_follow_steering_sequencer_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_kind,
  input  logic [lfss_pkg::SENS_W-1:0]    in_sensors,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_servo_write,
  output logic [lfss_pkg::SERVO_W-1:0]   out_servo_value,
  output logic [lfss_pkg::SPEED_W-1:0]   out_speed_target,
  output logic                           out_pid_preset,
  output logic                           out_brake,
  output logic                           out_stopped,
  output logic [lfss_pkg::PHASE_W-1:0]   out_turn_state,
  output logic [lfss_pkg::HITS_W-1:0]    out_hit_count,
  input  logic                           cfg_we,
  input  logic [lfss_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [lfss_pkg::CFG_W-1:0]     cfg_wdata
);
  import lfss_pkg::*;

  logic               in_v_r;
  logic               in_kind_r;
  logic [SENS_W-1:0]  in_sensors_r;
  logic               out_v_r;
  lfss_result_t       res_r;
  lfss_result_t       res_nxt;
  lfss_state_t        st_r;
  lfss_state_t        st_nxt;
  lfss_cfg_t          cfg_r;
  logic               advance;
  logic               fire;

  assign advance  = !out_v_r || out_ready;
  assign fire     = in_v_r && advance;
  assign in_ready = !in_v_r || advance;

  lfss_step u_step (
    .kind    (in_kind_r),
    .sensors (in_sensors_r),
    .st      (st_r),
    .cfg     (cfg_r),
    .st_nxt  (st_nxt),
    .res     (res_nxt)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_kind_r    <= in_kind;
      in_sensors_r <= in_sensors;
    end
  end

  // Tracker state: advance only when an item is evaluated
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.servo_pos   <= SERVO_CENTRE;
      st_r.steer       <= SERVO_CENTRE;
      st_r.tick_count  <= '0;
      st_r.blocks_left <= BLOCKS_RESET;
      st_r.phase       <= PHASE_NONE;
      st_r.halted      <= 1'b0;
      st_r.speed       <= SPEED_RESET;
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.interval_thr <= '0;
      cfg_r.slow_speed   <= SLOW_SPEED_RESET;
      cfg_r.fast_speed   <= FAST_SPEED_RESET;
      cfg_r.slow_blocks  <= SLOW_BLOCKS_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_INTERVAL_THR: cfg_r.interval_thr <= cfg_wdata;
        CFG_SLOW_SPEED:   cfg_r.slow_speed   <= cfg_wdata[SPEED_W-1:0];
        CFG_FAST_SPEED:   cfg_r.fast_speed   <= cfg_wdata[SPEED_W-1:0];
        CFG_SLOW_BLOCKS:  cfg_r.slow_blocks  <= cfg_wdata[BLOCK_W-1:0];
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_v_r;
  assign out_servo_write  = res_r.servo_write;
  assign out_servo_value  = res_r.servo_value;
  assign out_speed_target = res_r.speed_target;
  assign out_pid_preset   = res_r.pid_preset;
  assign out_brake        = res_r.brake;
  assign out_stopped      = res_r.stopped;
  assign out_turn_state   = res_r.turn_state;
  assign out_hit_count    = res_r.hit_count;

  // Once halted, the block never leaves the stopped state
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.halted |=> st_r.halted)
    else $error("halted state cleared");

  // Halting only happens when an item is evaluated
  a_halt_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(st_r.halted) |-> $past(fire))
    else $error("halt without an item");

  // A stalled input register implies it holds an item
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_v_r && out_v_r && !out_ready))
    else $error("input stalled while empty");

  // A stopped result that did not brake carries no servo write and no hits
  a_stopped_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stopped && !out_brake) |->
      (!out_servo_write && out_hit_count == '0 && !out_pid_preset))
    else $error("activity reported while stopped");

endmodule
